/* hw/rtl/tnpo_pkg.sv */
// Shared constants, widths and state type for the 3x+1 stopping-time core.
// Used by the core and by its port checker. No dependencies.
`timescale 1ns / 1ps

package tnpo_pkg;

	// Trajectory value width and start value width
	localparam int VALUE_WIDTH = 64;
	localparam int START_WIDTH = 32;

	// Digit-serial walk: one digit of the trajectory value per cycle.
	// VALUE_WIDTH is a multiple of DIGIT_W.
	localparam int DIGIT_W    = 16;
	localparam int NUM_DIGITS = VALUE_WIDTH / DIGIT_W;
	localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

	// Field widths
	localparam int STEP_W   = 16;
	localparam int COUNT_W  = 32;
	localparam int SUCC_W   = START_WIDTH + 2;
	localparam int EXCESS_W = START_WIDTH + 1;
	localparam int HALF_W   = START_WIDTH + 1;
	localparam int DIFF_W   = START_WIDTH + 3;
	localparam int ENTRY_W  = VALUE_WIDTH - 1;

	// Bit-serial prologue length counter
	localparam int SIDE_CNT_W = $clog2(SUCC_W + 1);

	// Map constants
	localparam int ENTRY_MIN = 16;
	localparam int TRIPLE    = 3;

	localparam logic [STEP_W-1:0] MAX_STEPS_RESET = STEP_W'(4095);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DELTA,
		ST_DIFF,
		ST_FINISH
	} state_t;

endpackage

/* hw/rtl/three_n_plus_one_stopping_time_core.sv */
// 3x+1 stopping-time core; depends on tnpo_pkg. Takes a start value n, walks the map.
// Each map step runs through the 16-bit digit-serial datapath on the 64-bit value.
// Throughput: one request at a time; the next is taken the cycle after its result is registered,
// while that result may still wait on out_ready.
// Reset: arst_n low clears control, counters and history; max_steps returns to 4095.
`timescale 1ns / 1ps

module three_n_plus_one_stopping_time_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [tnpo_pkg::STEP_W-1:0]             max_steps,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [tnpo_pkg::START_WIDTH-1:0]        start_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [tnpo_pkg::START_WIDTH-1:0]        power_below_n,
	output logic [tnpo_pkg::SUCC_W-1:0]             successor,
	output logic [tnpo_pkg::SUCC_W-1:0]             power_below_successor,
	output logic [tnpo_pkg::EXCESS_W-1:0]           excess,
	output logic signed [tnpo_pkg::SUCC_W-1:0]      delta,
	output logic [tnpo_pkg::STEP_W-1:0]             steps,
	output logic signed [tnpo_pkg::HALF_W-1:0]      half_delta_change,
	output logic [tnpo_pkg::ENTRY_W-1:0]            entry_power,
	output logic [tnpo_pkg::STEP_W-1:0]             max_steps_seen,
	output logic [tnpo_pkg::COUNT_W-1:0]            entries_at_sixteen,
	output logic [tnpo_pkg::COUNT_W-1:0]            items_done,
	output logic                                    overflow
);
	import tnpo_pkg::*;

	// Control
	state_t                 state_q, state_d;
	logic [STEP_W-1:0]      max_steps_q;
	logic                   load_item, proc, step_done, stop_walk, stop_ovf;
	logic                   do_delta, do_diff, do_finish;

	// Walk datapath
	logic [VALUE_WIDTH-1:0] val_q, val_nxt;
	logic [DIG_IDX_W-1:0]   dig_idx_q;
	logic                   at_first, at_last;
	logic                   odd_q, odd_cur;
	logic [1:0]             carry_q, carry_in, carry_nxt;
	logic                   is_one_q, one_acc_q, one_acc_nxt;
	logic                   pw_one_q, pw_bad_q, s16_q;
	logic                   one_base, bad_base, pw_one_nxt, pw_bad_nxt, s16_nxt;
	logic                   entry_hit, nbit, dig_nz, dig_pow;
	logic [DIGIT_W-1:0]     d0, dig_out;
	logic [DIGIT_W+1:0]     tri_sum;
	logic [STEP_W-1:0]      step_cnt_q;
	logic                   ovf_q;

	// History
	logic [VALUE_WIDTH-1:0] last_entry_q;
	logic [COUNT_W-1:0]     sixteen_cnt_q, item_cnt_q;
	logic [STEP_W-1:0]      best_q, best_nxt;

	// Bit-serial prologue: 3n+1 and the two leading powers
	logic [START_WIDTH-1:0] n_sh_q, p_q;
	logic                   nprev_q, sc_q;
	logic [1:0]             side_sum;
	logic [SUCC_W-1:0]      weight_q, sr_q, q_pow_q, excess_w;
	logic [SIDE_CNT_W-1:0]  side_cnt_q;
	logic                   side_busy;

	// Delta arithmetic
	logic signed [DIFF_W-1:0] delta_q, prev_delta_q, chg_q, chg_adj, chg_half;

	// Result registers
	logic                     out_valid_q;
	logic [START_WIDTH-1:0]   power_below_n_q;
	logic [SUCC_W-1:0]        successor_q, power_below_successor_q;
	logic [EXCESS_W-1:0]      excess_q;
	logic signed [SUCC_W-1:0] delta_out_q;
	logic [STEP_W-1:0]        steps_q, max_steps_seen_q;
	logic signed [HALF_W-1:0] half_q;
	logic [ENTRY_W-1:0]       entry_power_q;
	logic [COUNT_W-1:0]       entries_q, items_q;
	logic                     overflow_q;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Digit datapath: triple-plus-one with carry, or halve with the next digit's low bit
	assign at_first  = (dig_idx_q == '0);
	assign at_last   = (dig_idx_q == DIG_IDX_W'(NUM_DIGITS - 1));
	assign d0        = val_q[DIGIT_W-1:0];
	assign nbit      = at_last ? 1'b0 : val_q[DIGIT_W];
	assign odd_cur   = at_first ? val_q[0] : odd_q;
	assign carry_in  = at_first ? 2'd1 : carry_q;
	assign tri_sum   = (DIGIT_W+2)'(TRIPLE) * {2'b00, d0} + {{DIGIT_W{1'b0}}, carry_in};
	assign carry_nxt = tri_sum[DIGIT_W+1:DIGIT_W];
	assign dig_out   = odd_cur ? tri_sum[DIGIT_W-1:0] : {nbit, d0[DIGIT_W-1:1]};
	assign val_nxt   = {dig_out, val_q[VALUE_WIDTH-1:DIGIT_W]};

	// Track power-of-two and value-is-one over the digits of the new value
	assign dig_nz      = (dig_out != '0);
	assign dig_pow     = ((dig_out & (dig_out - DIGIT_W'(1))) == '0);
	assign one_base    = at_first ? 1'b0 : pw_one_q;
	assign bad_base    = at_first ? 1'b0 : pw_bad_q;
	assign pw_one_nxt  = one_base | dig_nz;
	assign pw_bad_nxt  = bad_base | (dig_nz & (one_base | !dig_pow |
		(at_first & (dig_out < DIGIT_W'(ENTRY_MIN)))));
	assign s16_nxt     = at_first ? (dig_out == DIGIT_W'(ENTRY_MIN)) : s16_q;
	assign one_acc_nxt = at_first ? (dig_out == DIGIT_W'(1)) : (one_acc_q & !dig_nz);
	assign entry_hit   = odd_cur & pw_one_nxt & !pw_bad_nxt;

	// Prologue bit: 3n+1 = n + 2n + 1, LSB first
	assign side_sum  = {1'b0, n_sh_q[0]} + {1'b0, nprev_q} + {1'b0, sc_q};
	assign side_busy = (side_cnt_q != '0);
	assign excess_w  = sr_q & ~q_pow_q;

	// Truncate the halved change toward zero
	assign chg_adj  = chg_q + $signed({{(DIFF_W-1){1'b0}}, chg_q[DIFF_W-1]});
	assign chg_half = chg_adj >>> 1;
	assign best_nxt = (step_cnt_q > best_q) ? step_cnt_q : best_q;

	// Next state and strobes
	always_comb begin
		state_d   = state_q;
		load_item = 1'b0;
		proc      = 1'b0;
		step_done = 1'b0;
		stop_walk = 1'b0;
		stop_ovf  = 1'b0;
		do_delta  = 1'b0;
		do_diff   = 1'b0;
		do_finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					load_item = 1'b1;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				if (at_first && is_one_q) begin
					stop_walk = 1'b1;
					state_d   = ST_DELTA;
				end else if (at_first && (step_cnt_q >= max_steps_q)) begin
					stop_walk = 1'b1;
					stop_ovf  = 1'b1;
					state_d   = ST_DELTA;
				end else begin
					proc = 1'b1;
					if (at_last) begin
						if (odd_cur && (carry_nxt != 2'd0)) begin
							stop_walk = 1'b1;
							stop_ovf  = 1'b1;
							state_d   = ST_DELTA;
						end else begin
							step_done = 1'b1;
						end
					end
				end
			end
			ST_DELTA: begin
				if (!side_busy) begin
					do_delta = 1'b1;
					state_d  = ST_DIFF;
				end
			end
			ST_DIFF: begin
				do_diff = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					do_finish = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and history registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q   <= MAX_STEPS_RESET;
			dig_idx_q     <= '0;
			step_cnt_q    <= '0;
			ovf_q         <= 1'b0;
			side_cnt_q    <= '0;
			last_entry_q  <= '0;
			sixteen_cnt_q <= '0;
			item_cnt_q    <= '0;
			best_q        <= '0;
			prev_delta_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_steps_q <= max_steps;
			end
			// Start a walk and the prologue
			if (load_item) begin
				dig_idx_q  <= '0;
				step_cnt_q <= '0;
				ovf_q      <= 1'b0;
				side_cnt_q <= SIDE_CNT_W'(SUCC_W);
			end else if (side_busy) begin
				side_cnt_q <= side_cnt_q - SIDE_CNT_W'(1);
			end
			// Advance the digit index
			if (proc) begin
				dig_idx_q <= at_last ? '0 : dig_idx_q + DIG_IDX_W'(1);
			end
			if (stop_walk) begin
				ovf_q <= stop_ovf;
			end
			// Commit a finished map step
			if (step_done) begin
				step_cnt_q <= step_cnt_q + STEP_W'(1);
				if (entry_hit) begin
					last_entry_q <= val_nxt;
					if (s16_nxt) begin
						sixteen_cnt_q <= sixteen_cnt_q + COUNT_W'(1);
					end
				end
			end
			// Retire the request
			if (do_finish) begin
				best_q       <= best_nxt;
				item_cnt_q   <= item_cnt_q + COUNT_W'(1);
				prev_delta_q <= delta_q;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// Walk datapath registers
	always_ff @(posedge clk) begin
		if (load_item) begin
			val_q    <= VALUE_WIDTH'(start_value);
			is_one_q <= (start_value == START_WIDTH'(1));
		end
		if (proc) begin
			val_q     <= val_nxt;
			odd_q     <= odd_cur;
			carry_q   <= carry_nxt;
			pw_one_q  <= pw_one_nxt;
			pw_bad_q  <= pw_bad_nxt;
			s16_q     <= s16_nxt;
			one_acc_q <= one_acc_nxt;
		end
		if (step_done) begin
			is_one_q <= one_acc_nxt;
		end
	end

	// Prologue shift registers: one bit of n per cycle
	always_ff @(posedge clk) begin
		if (load_item) begin
			n_sh_q   <= start_value;
			nprev_q  <= 1'b0;
			sc_q     <= 1'b1;
			weight_q <= SUCC_W'(1);
			sr_q     <= '0;
			p_q      <= START_WIDTH'(1);
			q_pow_q  <= SUCC_W'(1);
		end else if (side_busy) begin
			n_sh_q   <= {1'b0, n_sh_q[START_WIDTH-1:1]};
			nprev_q  <= n_sh_q[0];
			sc_q     <= side_sum[1];
			sr_q     <= {side_sum[0], sr_q[SUCC_W-1:1]};
			weight_q <= {weight_q[SUCC_W-2:0], 1'b0};
			if (n_sh_q[0]) begin
				p_q <= weight_q[START_WIDTH-1:0];
			end
			if (side_sum[0]) begin
				q_pow_q <= weight_q;
			end
		end
	end

	// Delta, its change, and the result registers
	always_ff @(posedge clk) begin
		if (do_delta) begin
			delta_q <= $signed(DIFF_W'(excess_w)) - $signed(DIFF_W'(p_q));
		end
		if (do_diff) begin
			chg_q <= delta_q - prev_delta_q;
		end
		if (do_finish) begin
			power_below_n_q         <= p_q;
			successor_q             <= sr_q;
			power_below_successor_q <= q_pow_q;
			excess_q                <= excess_w[EXCESS_W-1:0];
			delta_out_q             <= delta_q[SUCC_W-1:0];
			steps_q                 <= step_cnt_q;
			half_q                  <= chg_half[HALF_W-1:0];
			entry_power_q           <= last_entry_q[ENTRY_W-1:0];
			max_steps_seen_q        <= best_nxt;
			entries_q               <= sixteen_cnt_q;
			items_q                 <= item_cnt_q + COUNT_W'(1);
			overflow_q              <= ovf_q;
		end
	end

	assign power_below_n         = power_below_n_q;
	assign successor             = successor_q;
	assign power_below_successor = power_below_successor_q;
	assign excess                = excess_q;
	assign delta                 = delta_out_q;
	assign steps                 = steps_q;
	assign half_delta_change     = half_q;
	assign entry_power           = entry_power_q;
	assign max_steps_seen        = max_steps_seen_q;
	assign entries_at_sixteen    = entries_q;
	assign items_done            = items_q;
	assign overflow              = overflow_q;

endmodule

/* hw/rtl/tnpo_checker.sv */
// Port-level checks for the 3x+1 stopping-time core, bound to its top level.
// Depends on tnpo_pkg and three_n_plus_one_stopping_time_core.
`timescale 1ns / 1ps

module tnpo_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [tnpo_pkg::SUCC_W-1:0]    successor,
	input logic [tnpo_pkg::SUCC_W-1:0]    power_below_successor,
	input logic [tnpo_pkg::EXCESS_W-1:0]  excess,
	input logic [tnpo_pkg::STEP_W-1:0]    steps,
	input logic [tnpo_pkg::STEP_W-1:0]    max_steps_seen
);
	import tnpo_pkg::*;

	// Excess and power add back up to 3n+1
	a_excess_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (({1'b0, excess} + power_below_successor) == successor))
		else $error("excess plus power differs from successor");

	// Power of 3n+1 is a single bit
	a_power_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(power_below_successor))
		else $error("power_below_successor is not a power of two");

	// Excess stays below its power
	a_excess_below: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, excess} < power_below_successor))
		else $error("excess not below its power");

	// Running maximum covers this request
	a_max_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (max_steps_seen >= steps))
		else $error("max_steps_seen below steps");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(successor) && $stable(steps))
		else $error("stalled result changed");

endmodule

bind three_n_plus_one_stopping_time_core tnpo_checker u_tnpo_checker (.*);
